// ===== hw/rtl/lpfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lpfd_pkg;

   localparam int HEADER_BYTES = 8;
   localparam int HDR_CNT_W    = 3;
   localparam logic [HDR_CNT_W-1:0] HDR_LAST_IDX = HDR_CNT_W'(HEADER_BYTES - 1);
   localparam int STORE_W      = 8 * (HEADER_BYTES - 1);
   localparam int RSP_TDATA_W  = 72;
   localparam logic [31:0] MAX_LEN_RESET = 32'd65536;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_ERROR  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_BODY   = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_MAGIC = 2'd1,
      ERR_LONG  = 2'd2,
      ERR_SHORT = 2'd3
   } err_code_type;

   typedef enum logic {
      CSR_MAGIC   = 1'b0,
      CSR_MAX_LEN = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  magic_value;
      logic [31:0] max_frame_len;
   } cfg_type;

   typedef struct packed {
      kind_type     kind;
      logic [7:0]   version;
      logic [15:0]  service_id;
      logic [31:0]  frame_len;
      logic [7:0]   body_byte;
      err_code_type error_code;
      logic         last;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lpfd_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpfd_csr (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_valid,
   input  wire lpfd_pkg::csr_index_type csr_index,
   input  wire [31:0]            csr_data,
   output lpfd_pkg::cfg_type     cfg
);
   import lpfd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MAGIC:   cfg_in.magic_value   = csr_data[7:0];
            CSR_MAX_LEN: cfg_in.max_frame_len = csr_data;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_value   <= 8'd0;
         cfg_ff.max_frame_len <= MAX_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lpfd_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpfd_parser (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   byte_fire,
   input  wire [7:0]             data_byte,
   input  wire lpfd_pkg::cfg_type cfg,
   output logic                  res_valid,
   output lpfd_pkg::rsp_item_type res
);
   import lpfd_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [HDR_CNT_W-1:0]   count_ff, count_in;
   logic [STORE_W-1:0]     store_ff, store_in;
   logic [31:0]            remain_ff, remain_in;

   logic [7:0]   hdr_version;
   logic [7:0]   hdr_magic;
   logic [15:0]  hdr_sid;
   logic [31:0]  hdr_len;
   logic [31:0]  body_len;
   err_code_type hdr_err;
   logic         hdr_done;

   // Header bytes are shifted in oldest-first, so the version sits on top.
   assign hdr_version = store_ff[STORE_W-1 -: 8];
   assign hdr_magic   = store_ff[STORE_W-9 -: 8];
   assign hdr_sid     = store_ff[STORE_W-17 -: 16];
   assign hdr_len     = {store_ff[23:0], data_byte};
   assign body_len    = hdr_len - 32'(HEADER_BYTES);
   assign hdr_done    = (phase_ff == PH_HEADER) && (count_ff == HDR_LAST_IDX);

   always_comb begin
      if (hdr_magic != cfg.magic_value)          hdr_err = ERR_MAGIC;
      else if (hdr_len > cfg.max_frame_len)      hdr_err = ERR_LONG;
      else if (hdr_len < 32'(HEADER_BYTES))      hdr_err = ERR_SHORT;
      else                                       hdr_err = ERR_NONE;
   end

   // next state
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      store_in  = store_ff;
      remain_in = remain_ff;
      if (byte_fire) begin
         case (phase_ff)
            PH_BODY: begin
               remain_in = remain_ff - 32'd1;
               if (remain_ff <= 32'd1) begin
                  phase_in = PH_HEADER;
                  count_in = '0;
               end
            end
            PH_HEADER: begin
               if (!hdr_done) begin
                  store_in = {store_ff[STORE_W-9:0], data_byte};
                  count_in = count_ff + HDR_CNT_W'(1);
               end else begin
                  count_in = '0;
                  if (hdr_err != ERR_NONE) begin
                     phase_in = PH_ERROR;
                  end else begin
                     remain_in = body_len;
                     phase_in  = (body_len == 32'd0) ? PH_HEADER : PH_BODY;
                  end
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // result
   always_comb begin
      res_valid = 1'b0;
      res       = '0;
      if (byte_fire) begin
         case (phase_ff)
            PH_BODY: begin
               res_valid     = 1'b1;
               res.kind      = KIND_BODY;
               res.body_byte = data_byte;
               res.last      = (remain_ff == 32'd1);
            end
            PH_HEADER: begin
               if (hdr_done) begin
                  res_valid      = 1'b1;
                  res.version    = hdr_version;
                  res.service_id = hdr_sid;
                  res.frame_len  = hdr_len;
                  if (hdr_err != ERR_NONE) begin
                     res.kind       = KIND_ERROR;
                     res.error_code = hdr_err;
                  end else begin
                     res.kind = KIND_HEADER;
                     res.last = (body_len == 32'd0);
                  end
               end
            end
            default: res_valid = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         count_ff  <= '0;
         remain_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

   a_body_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> remain_ff != 32'd0)
      else $error("body phase with no bytes left");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERROR |=> phase_ff == PH_ERROR && !res_valid)
      else $error("left sticky error phase");

   a_header_restart: assert property (@(posedge clock) disable iff (reset)
      byte_fire && phase_ff == PH_BODY && res.last |=> phase_ff == PH_HEADER && count_ff == '0)
      else $error("no header restart after last body byte");

endmodule

`default_nettype wire

// ===== hw/rtl/lpfd_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lpfd_out_buf (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  wire lpfd_pkg::rsp_item_type push_item,
   output logic                  space,
   output logic                  out_valid,
   input  wire                   out_ready,
   output lpfd_pkg::rsp_item_type out_item
);
   import lpfd_pkg::*;

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type main_ff, main_in;
   rsp_item_type skid_ff, skid_in;
   logic         pop;

   assign pop   = main_valid_ff && out_ready;
   assign space = !skid_valid_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // input side is held off while the skid entry is occupied
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push && (!main_valid_ff || pop)) begin
         main_in       = push_item;
         main_valid_in = 1'b1;
      end else if (push) begin
         skid_in       = push_item;
         skid_valid_in = 1'b1;
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_valid_ff;
   assign out_item  = main_ff;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry without head entry");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("push into full output stage");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && pop |=> main_valid_ff && !skid_valid_ff && main_ff == $past(skid_ff))
      else $error("skid entry lost on pop");

endmodule

`default_nettype wire

// ===== hw/rtl/length_prefixed_frame_deframer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Output: a result is registered in the output stage before it appears on rsp_.
// Throughput: one byte per cycle while the output stage has room; the frame state
// updates per byte, and a two-entry output stage takes bytes while one result waits.
// Reset (synchronous): header phase, counters zero, magic 0, max length 65536,
// output stage empty. The header shift store is not reset.

module length_prefixed_frame_deframer (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   input  wire [7:0]                  req_tdata,   // [7:0] data_byte
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   // [7:0] version, [23:8] service_id, [55:24] frame_len, [63:56] body_byte,
   // [65:64] error_code, [71:66] zero
   output logic [lpfd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [1:0]                 rsp_tuser,   // [1:0] kind
   output logic                       rsp_tlast,   // last
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire                        csr_index,
   input  wire [31:0]                 csr_data
);
   import lpfd_pkg::*;

   cfg_type      cfg;
   logic         byte_fire;
   logic         res_valid;
   rsp_item_type res;
   rsp_item_type out_item;
   logic         space;

   assign req_tready = space;
   assign byte_fire  = req_tvalid && space;
   assign csr_ready  = 1'b1;

   lpfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index_type'(csr_index)),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lpfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (byte_fire),
      .data_byte (req_tdata),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   lpfd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_item (res),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {6'd0, out_item.error_code, out_item.body_byte, out_item.frame_len,
                       out_item.service_id, out_item.version};
   assign rsp_tuser = out_item.kind;
   assign rsp_tlast = out_item.last;

endmodule

`default_nettype wire

// ===== dv/lpfd_checker.sv =====
`timescale 1ns / 1ps

module lpfd_checker (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_tvalid,
   input  wire                             req_tready,
   input  wire [7:0]                       req_tdata,
   input  wire                             rsp_tvalid,
   input  wire                             rsp_tready,
   input  wire [lpfd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  wire [1:0]                       rsp_tuser,
   input  wire                             rsp_tlast,
   input  wire                             csr_valid,
   input  wire                             csr_ready,
   input  wire                             csr_index,
   input  wire [31:0]                      csr_data,
   output int                              mismatches,
   output int                              outstanding
);
   import lpfd_pkg::*;

   // shadow of the deframer state
   phase_type            stream_phase;
   logic [HDR_CNT_W-1:0] hdr_taken;
   logic [STORE_W-1:0]   hdr_shift;
   logic [31:0]          body_left;
   cfg_type              cfg;
   rsp_item_type         pending_results[$];
   int                   fail_cnt = 0;

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_cnt++;
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      rsp_item_type item;
      logic [31:0]  flen;
      err_code_type err;
      item = '0;
      case (stream_phase)
         PH_BODY: begin
            item.kind      = KIND_BODY;
            item.body_byte = b;
            item.last      = (body_left == 32'd1);
            pending_results = {pending_results, item};
            body_left--;
            if (body_left == 32'd0) begin
               stream_phase = PH_HEADER;
               hdr_taken    = '0;
            end
         end
         PH_HEADER: begin
            if (hdr_taken != HDR_LAST_IDX) begin
               hdr_shift = {hdr_shift[STORE_W-9:0], b};
               hdr_taken++;
            end else begin
               flen            = {hdr_shift[23:0], b};
               item.version    = hdr_shift[STORE_W-1 -: 8];
               item.service_id = hdr_shift[STORE_W-17 -: 16];
               item.frame_len  = flen;
               hdr_taken       = '0;
               // magic beats length; too long beats too short
               if (hdr_shift[STORE_W-9 -: 8] != cfg.magic_value)
                  err = ERR_MAGIC;
               else if (flen > cfg.max_frame_len)
                  err = ERR_LONG;
               else if (flen < 32'(HEADER_BYTES))
                  err = ERR_SHORT;
               else
                  err = ERR_NONE;
               if (err != ERR_NONE) begin
                  item.kind       = KIND_ERROR;
                  item.error_code = err;
                  stream_phase    = PH_ERROR;
               end else begin
                  body_left    = flen - 32'(HEADER_BYTES);
                  item.kind    = KIND_HEADER;
                  item.last    = (body_left == 32'd0);
                  stream_phase = (body_left == 32'd0) ? PH_HEADER : PH_BODY;
               end
               pending_results = {pending_results, item};
            end
         end
         default: ;  // sticky error: bytes are dropped until reset
      endcase
   endtask

   always @(posedge clock) begin : monitor
      rsp_item_type want;
      if (reset) begin
         stream_phase      = PH_HEADER;
         hdr_taken         = '0;
         body_left         = '0;
         cfg.magic_value   = 8'd0;
         cfg.max_frame_len = MAX_LEN_RESET;
         pending_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_MAGIC:   cfg.magic_value   = csr_data[7:0];
               CSR_MAX_LEN: cfg.max_frame_len = csr_data;
               default:     ;
            endcase
         end
         // compare before predicting: a result never belongs to this edge's byte
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result transaction: kind %0d", rsp_tuser);
               fail_cnt++;
            end else begin
               want = pending_results.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_tuser));
               check_field("version", 32'(want.version), 32'(rsp_tdata[7:0]));
               check_field("service_id", 32'(want.service_id), 32'(rsp_tdata[23:8]));
               check_field("frame_len", want.frame_len, rsp_tdata[55:24]);
               check_field("body_byte", 32'(want.body_byte), 32'(rsp_tdata[63:56]));
               check_field("error_code", 32'(want.error_code), 32'(rsp_tdata[65:64]));
               check_field("last", 32'(want.last), 32'(rsp_tlast));
               check_field("tdata pad", 32'd0, 32'(rsp_tdata[71:66]));
            end
         end
         if (req_tvalid && req_tready)
            deframe_byte(req_tdata);
      end
      mismatches  <= fail_cnt;
      outstanding <= pending_results.size();
   end

endmodule

// ===== dv/tb_length_prefixed_frame_deframer.sv =====
`timescale 1ns / 1ps

module tb_length_prefixed_frame_deframer;
   import lpfd_pkg::*;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [7:0]             req_tdata  = 8'd0;
   logic                   rsp_tready = 1'b0;
   logic                   csr_valid  = 1'b0;
   logic                   csr_index  = 1'b0;
   logic [31:0]            csr_data   = 32'd0;
   wire                    req_tready;
   wire                    rsp_tvalid;
   wire  [RSP_TDATA_W-1:0] rsp_tdata;
   wire  [1:0]             rsp_tuser;
   wire                    rsp_tlast;
   wire                    csr_ready;
   int                     mismatches;
   int                     outstanding;

   bit          steady = 1'b0;   // no idling on either side
   int          sent   = 0;
   logic [7:0]  cur_magic;
   logic [31:0] cur_max;

   length_prefixed_frame_deframer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   lpfd_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 13);
   end

   // valid stays high between back-to-back bytes; ready is sampled mid-cycle
   task automatic send_byte(input logic [7:0] b);
      bit took;
      if (!steady) begin
         while ($urandom_range(99) < 13) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      sent++;
   endtask

   task automatic send_frame(input logic [7:0] ver, input logic [7:0] magic,
                             input logic [15:0] sid, input logic [31:0] len,
                             input int body_n);
      send_byte(ver);
      send_byte(magic);
      send_byte(sid[15:8]);
      send_byte(sid[7:0]);
      for (int i = 3; i >= 0; i--)
         send_byte(len[8*i +: 8]);
      repeat (body_n) send_byte(8'($urandom_range(255)));
   endtask

   task automatic random_frame();
      int unsigned room;
      logic [31:0] len;
      room = (cur_max - 32'd8 > 32'd24) ? 24 : cur_max - 32'd8;
      // now and then a longer body, where the limit allows it
      if ($urandom_range(19) == 0 && cur_max - 32'd8 > 32'd24)
         room = (cur_max - 32'd8 > 32'd160) ? 160 : cur_max - 32'd8;
      len = 32'd8 + $urandom_range(room);
      if ($urandom_range(9) == 0 && cur_max <= 32'd200)
         len = cur_max;
      send_frame(8'($urandom_range(255)), cur_magic, 16'($urandom_range(65535)),
                 len, len - 32'd8);
   endtask

   // stop the stream and let every result and the pipeline settle
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_beat(input csr_index_type idx, input logic [31:0] value);
      bit took;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do begin
         @(negedge clock);
         took = csr_ready;
         @(posedge clock);
      end while (!took);
   endtask

   task automatic configure(input logic [7:0] magic, input logic [31:0] max_len);
      csr_beat(CSR_MAGIC, {24'd0, magic});
      csr_beat(CSR_MAX_LEN, max_len);
      csr_valid <= 1'b0;
      cur_magic = magic;
      cur_max   = max_len;
   endtask

   initial begin
      logic [31:0] len;
      int          start;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty body at reset settings, field extremes, length at the limit
      cur_magic = 8'd0;
      cur_max   = MAX_LEN_RESET;
      send_frame(8'h00, 8'h00, 16'h0000, 32'd8, 0);
      send_frame(8'hFF, 8'h00, 16'hFFFF, 32'd10, 2);
      drain();
      configure(8'hFF, 32'd8);
      send_frame(8'hA5, 8'hFF, 16'h8001, 32'd8, 0);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0:       configure(8'($urandom_range(255)), MAX_LEN_RESET);
            1:       configure(8'hFF, 32'hFFFF_FFFF);
            2:       configure(8'($urandom_range(255)), $urandom_range(60, 8));
            default: configure(8'h00, 32'd8);
         endcase
         steady <= (ph == 1);
         start = sent;
         while (sent - start < 90) random_frame();
         drain();
      end
      steady <= 1'b0;

      // one error frame closes the run; the error is sticky until reset
      configure(8'($urandom_range(255)), $urandom_range(4000, 8));
      case ($urandom_range(2))
         0: send_frame(8'($urandom_range(255)), cur_magic ^ 8'($urandom_range(255, 1)),
                       16'($urandom_range(65535)), $urandom(), 0);
         1: begin
            len = $urandom_range(1) ? 32'hFFFF_FFFF
                                    : $urandom_range(32'hFFFF_FFFF, cur_max + 32'd1);
            send_frame(8'($urandom_range(255)), cur_magic, 16'($urandom_range(65535)),
                       len, 0);
         end
         default: send_frame(8'($urandom_range(255)), cur_magic,
                             16'($urandom_range(65535)), $urandom_range(7), 0);
      endcase
      // dropped by the block after the error
      repeat (12) send_byte(8'($urandom_range(255)));
      drain();

      if (mismatches == 0 && outstanding == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
